[rtl/core/masw_pkg.sv]
// ----------------------------------------------------------------------------
// masw_pkg
// Shared types and constants for the moving-average block with start-up
// window: item layouts, register width and reset, request codes.
// ----------------------------------------------------------------------------
package masw_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;

  // Window length after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;

  // Request codes carried in the func field
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Input item
  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       window_full;
  } out_item_t;

endpackage

[rtl/core/masw_ram.sv]
// ----------------------------------------------------------------------------
// masw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module masw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/masw_div.sv]
// ----------------------------------------------------------------------------
// masw_div
// Unsigned restoring divider, one quotient bit per cycle. When the
// iteration ends, done pulses for one cycle with the quotient held after it.
// ----------------------------------------------------------------------------
module masw_div #(
  parameter int W  = 22,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] acc;
  logic [DW-1:0] dsr;
  logic [W-1:0]  quo;
  logic [DW:0]   acc_sh;
  logic [DW:0]   diff;

  // Trial subtract: borrow in the top bit means the bit is zero
  assign acc_sh   = {acc, quo[W-1]};
  assign diff     = acc_sh - {1'b0, dsr};
  assign quotient = quo;

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      acc <= diff[DW] ? acc_sh[DW-1:0] : diff[DW-1:0];
      quo <= {quo[W-2:0], ~diff[DW]};
    end
  end

  // Partial remainder stays below a non-zero divisor
  a_rem_below_dsr: assert property (@(posedge clk) disable iff (rst)
    busy && !start && dsr != '0 |-> acc < dsr)
    else $error("divider remainder not below divisor");

  // Done only as the iteration ends
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while busy");

endmodule

[rtl/core/moving_average_startup_window.sv]
// ----------------------------------------------------------------------------
// moving_average_startup_window
// Flow: a push item, once accepted, passes the ring read and sum update,
//   then the one-bit-per-cycle divider, then the output register.
// Items: a new item is taken only in the idle state, so not before the last
//   push result has entered the output register; a clear item is handled
//   in the idle state without leaving it.
// Reset: window length 16, sum, count and pointer zero, no clearing pass;
//   ring entries are only read once written since the last clear.
// ----------------------------------------------------------------------------
module moving_average_startup_window
  import masw_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                 state;
  logic [CFG_W-1:0]           window_length;
  logic signed [SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]           held_count;
  logic [PTR_W-1:0]           write_pointer;
  logic signed [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0]        avg;
  logic                       full_res;

  logic [CNT_W-1:0]           eff_len;
  logic                       was_full;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SUM_W-1:0]    s_ext;
  logic signed [SUM_W-1:0]    old_ext;
  logic signed [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           ptr_inc;
  logic [PTR_W-1:0]           ptr_next;
  logic [SUM_W-1:0]           div_dividend;
  logic                       div_done;
  logic [SUM_W-1:0]           div_quotient;
  logic [SUM_W-1:0]           q_signed;
  logic                       out_free;

  // Effective window: zero reads as one, saturate at the ring depth
  always_comb begin
    if (window_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(window_length);
    end
  end

  assign was_full = (held_count >= eff_len);
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sample ring; read address is the slot about to be overwritten
  masw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPD),
    .waddr (write_pointer),
    .wdata (smp),
    .raddr (write_pointer),
    .rdata (ram_rdata)
  );

  // Running sum update: drop oldest once full, add newest
  assign s_ext    = SUM_W'(smp);
  assign old_ext  = SUM_W'($signed(ram_rdata));
  assign sum_next = running_sum + s_ext - (was_full ? old_ext : SUM_W'(0));

  assign count_next = was_full ? held_count : held_count + CNT_W'(1);
  assign ptr_inc    = CNT_W'(write_pointer) + CNT_W'(1);
  assign ptr_next   = (ptr_inc == eff_len) ? '0 : PTR_W'(ptr_inc);

  // Divide magnitude, restore sign afterwards (truncation toward zero)
  assign div_dividend = running_sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(running_sum))
                                             : SUM_W'(running_sum);
  assign q_signed     = running_sum[SUM_W-1] ? (SUM_W'(0) - div_quotient)
                                             : div_quotient;

  masw_div #(
    .W  (SUM_W),
    .DW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (div_dividend),
    .divisor  (held_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer and history control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= CFG_RESET;
      running_sum   <= '0;
      held_count    <= '0;
      write_pointer <= '0;
      out_valid     <= 1'b0;
    end else begin
      // a new result in the done state reloads the register instead
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.func == FUNC_CLEAR) begin
              running_sum   <= '0;
              held_count    <= '0;
              write_pointer <= '0;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          running_sum   <= sum_next;
          held_count    <= count_next;
          write_pointer <= ptr_next;
          state         <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Register write sets the length and empties the history
      if (cfg_we) begin
        window_length <= cfg_wdata;
        running_sum   <= '0;
        held_count    <= '0;
        write_pointer <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      smp <= in_data.sample;
    end
    if (state == ST_DIV && div_done) begin
      avg      <= q_signed[SAMPLE_W-1:0];
      full_res <= was_full;
    end
    if (state == ST_DONE && out_free) begin
      out_data.average     <= $signed(avg);
      out_data.window_full <= full_res;
    end
  end

  // Count never passes the window
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    held_count <= eff_len)
    else $error("held count beyond window length");

  // Pointer always addresses a slot inside the window
  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(write_pointer) < eff_len)
    else $error("write pointer outside window");

  // Sum update is always followed by the divider start
  a_upd_then_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |=> state == ST_START)
    else $error("sequencer skipped divider start");

  // Divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside divide state");

endmodule

[bench/moving_average_startup_window_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_average_startup_window_tb
// Self-checking bench for the sliding-window mean. A short table of directed
// items (extremes, clears, window lengths of 1, 2 and 64) is followed by
// random segments, each with its own window length and handshake idling
// pattern. Every result is checked against a local running-sum predictor or
// against the expectation typed into the directed table.
module moving_average_startup_window_tb;
  import masw_pkg::*;

  localparam int MAX_WIN      = 64;
  localparam int SUM_W        = 22;
  localparam int DRAIN_CYCLES = 32;   // idle wait after all results are back
  localparam int HOLD_CYCLES  = 400;
  localparam int SEG_ITEMS    = 68;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic [1:0] {ROW_CFG, ROW_PUSH, ROW_CLEAR} row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        value;
    bit        typed;
    int        exp_avg;
    bit        exp_full;
  } row_t;

  // DUT connections
  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Expectation typed into the table, travelling alongside the item
  logic             row_typed;
  out_item_t        row_exp;

  // Predictor state
  logic        [CFG_W-1:0]    win_len;
  logic signed [SAMPLE_W-1:0] hist_ring [0:MAX_WIN-1];
  logic signed [SUM_W-1:0]    hist_sum;
  logic        [6:0]          hist_count;
  logic        [5:0]          hist_wp;

  out_item_t  mean_expected [$];
  row_t       plan [$];
  idle_mode_e idle_mode = IDLE_NONE;
  int         hold_requests = 0;
  int         mismatches = 0;
  int         pushes_seen = 0;
  int         clears_seen = 0;
  int         cfg_writes = 0;
  int         means_checked = 0;

  moving_average_startup_window #(
    .MAX_WINDOW (MAX_WIN)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_history();
    for (int i = 0; i < MAX_WIN; i++) hist_ring[i] = '0;
    hist_sum   = '0;
    hist_count = '0;
    hist_wp    = '0;
  endfunction

  // Push one sample, return the mean of the samples now held
  function automatic out_item_t predict_mean(logic signed [SAMPLE_W-1:0] s);
    int        len;
    int        slot;
    int        sum_i;
    int        q;
    out_item_t r;
    len = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : int'(win_len));
    slot = hist_wp % len;
    if (hist_count < len) begin
      hist_count++;
    end else begin
      hist_sum -= hist_ring[slot];   // window full: drop the oldest
    end
    hist_ring[slot] = s;
    hist_sum += s;
    hist_wp = 6'((slot + 1) % len);
    sum_i = hist_sum;
    q = sum_i / int'(hist_count);    // truncates toward zero
    r.average     = q[SAMPLE_W-1:0];
    r.window_full = (hist_count >= len);
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 52;
      IDLE_BOTH: return 30;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 52;
      IDLE_BOTH: return 30;
      default:   return 0;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.func = chance(4) ? FUNC_CLEAR : FUNC_PUSH;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       it.sample = 16'sh7FFF;
      1:       it.sample = 16'sh8000;
      2:       it.sample = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      default: it.sample = SAMPLE_W'($urandom());
    endcase
    return it;
  endfunction

  // Called and returns at a falling edge
  task automatic offer_item(input in_item_t item, input bit typed, input out_item_t res);
    while (chance(send_idle_pct())) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= item;
    row_typed <= typed;
    row_exp   <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Only written once all results are back and a clear can have settled
  task automatic write_window(input int len);
    in_valid <= 1'b0;
    while (mean_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(len);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    if (mismatches < MAX_REPORTS)
      $display("mismatch: %s: expected avg %0d full %0b, got avg %0d full %0b",
               what, want.average, want.window_full, got.average, got.window_full);
    mismatches++;
  endfunction

  // ---------------------------------------------------------------- receiver

  // Random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !chance(recv_stall_pct());
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      // results first: none can belong to an item taken at this edge
      if (out_valid && out_ready) begin
        if (mean_expected.size() == 0) begin
          note_mismatch("result with no average pending", '0, out_data);
        end else begin
          want = mean_expected.pop_front();
          means_checked++;
          if (out_data.average !== want.average)
            note_mismatch("average", want, out_data);
          else if (out_data.window_full !== want.window_full)
            note_mismatch("window_full", want, out_data);
        end
      end
      if (cfg_we) begin
        win_len = cfg_wdata;
        clear_history();
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_CLEAR) begin
          clear_history();
          clears_seen++;
        end else begin
          want = predict_mean(in_data.sample);
          if (row_typed) want = row_exp;
          mean_expected.push_back(want);
          pushes_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    in_item_t  item;
    out_item_t res;
    int        seg_len [8];
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = CFG_RESET;
    row_typed = 1'b0;
    row_exp   = '0;
    win_len   = CFG_RESET;
    clear_history();
    seg_len = '{64, 1, 2, 37, 64, 5, 16, 64};

    // Directed table: kind, value, typed?, expected average, expected full
    plan.push_back('{ROW_PUSH,   32767, 1'b1,  32767, 1'b0});  // default window of 16
    plan.push_back('{ROW_PUSH,  -32768, 1'b1,      0, 1'b0});  // -1/2 truncates to 0
    plan.push_back('{ROW_CLEAR,     -1, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,  -32768, 1'b1, -32768, 1'b0});
    plan.push_back('{ROW_PUSH,       0, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_CFG,        1, 1'b0,      0, 1'b0});  // shortest window
    plan.push_back('{ROW_PUSH,     100, 1'b1,    100, 1'b1});
    plan.push_back('{ROW_PUSH,      -5, 1'b1,     -5, 1'b1});
    plan.push_back('{ROW_PUSH,   32767, 1'b1,  32767, 1'b1});
    plan.push_back('{ROW_PUSH,  -32768, 1'b1, -32768, 1'b1});
    plan.push_back('{ROW_CFG,        2, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,      -3, 1'b1,     -3, 1'b0});
    plan.push_back('{ROW_PUSH,       0, 1'b1,     -1, 1'b1});  // -1.5 toward zero
    plan.push_back('{ROW_PUSH,       4, 1'b1,      2, 1'b1});  // oldest dropped
    plan.push_back('{ROW_CLEAR,  23130, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,       7, 1'b1,      7, 1'b0});
    plan.push_back('{ROW_CFG,       64, 1'b0,      0, 1'b0});  // longest window
    plan.push_back('{ROW_PUSH,   32767, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,   32767, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,  -32768, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,   12345, 1'b0,      0, 1'b0});
    plan.push_back('{ROW_PUSH,  -12345, 1'b0,      0, 1'b0});

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_window(plan[i].value);
      end else begin
        item.func   = (plan[i].kind == ROW_CLEAR) ? FUNC_CLEAR : FUNC_PUSH;
        item.sample = plan[i].value[SAMPLE_W-1:0];
        res.average     = plan[i].exp_avg[SAMPLE_W-1:0];
        res.window_full = plan[i].exp_full;
        offer_item(item, plan[i].typed, res);
      end
    end

    // Random segments, each with its own window length and idling pattern
    for (int seg = 0; seg < 8; seg++) begin
      in_valid <= 1'b0;
      @(negedge clk);
      write_window(seg_len[seg]);
      idle_mode = idle_mode_e'(seg % 4);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        item = random_item();
        // last segment: fill the long window with the most negative value
        if (seg == 7 && n < MAX_WIN + 2) begin
          item.func   = FUNC_PUSH;
          item.sample = 16'sh8000;
        end
        // long receiver hold-off while items keep coming
        if (seg == 4 && n == 2) hold_requests++;
        offer_item(item, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (mean_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mean_expected.size() != 0) begin
      mismatches++;
      $display("%0d averages never arrived", mean_expected.size());
    end

    $display("Run covered %0d samples and %0d clears over %0d window settings.",
             pushes_seen, clears_seen, cfg_writes);
    $display("%0d averages checked, %0d mismatches.", means_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout with %0d averages outstanding", mean_expected.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
